### design/wlrs_pkg.sv
`default_nettype none

package wlrs_pkg;

    // Size of the record store, in 16-byte slots
    localparam int SLOT_COUNT = 128;
    localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    // Widths fixed by the record layout
    localparam int NEXT_SLOT_W = 7;
    localparam int SEQ_W       = 8;
    localparam int LEVEL_W     = 6;
    localparam int FIDX_W      = 16;
    localparam int REG_INDEX_W = 2;
    localparam int REG_DATA_W  = 16;

    localparam logic [15:0] MAGIC_LOW  = 16'h8fea;
    localparam logic [15:0] MAGIC_HIGH = 16'hd591;

    localparam logic [SEQ_W-1:0] SEQ_NONE = 8'hff;

    typedef logic [SLOT_W-1:0]      slot_idx_t;
    typedef logic [REG_INDEX_W-1:0] reg_index_t;

    // Configuration register indexes
    localparam reg_index_t REG_DC_LEVEL   = 2'd0;
    localparam reg_index_t REG_MODE       = 2'd1;
    localparam reg_index_t REG_FILE_INDEX = 2'd2;

    // Fields kept for the newest record seen so far
    typedef struct packed {
        logic [FIDX_W-1:0]  file_index;
        logic               mode;
        logic [LEVEL_W-1:0] dc_level;
    } rec_fields_t;

endpackage

`default_nettype wire

### design/wear_level_record_scanner.sv
`default_nettype none

// Wear-leveling record scanner. Feed it the first and last 32-bit words of
// every 16-byte slot of the record store, in slot order, one beat per slot,
// and mark the last slot with final_slot. A slot holds a valid record when
// the magic halves (0x8fea in the low half of the first word, 0xd591 in the
// high half of the last word) both match; the newest valid record is the one
// with the smallest 8-bit sequence number under wraparound comparison, and
// the earliest slot wins a tie. Only the final beat of a scan produces a
// result beat: the newest record's level, mode and file index (all zero when
// nothing was found), the slot and sequence number for the next record to
// program (the slot after the newest with sequence minus one, or slot 0 with
// 0xff when nothing was found), and the two packed words to write there,
// built from the write_* configuration registers. The scan state then clears
// for the next scan. A slot beat is taken every cycle unless the input is stalled:
// the compare-and-keep logic sits between the input handshake and a single result
// register, so a result appears in the cycle after its final beat; a result
// beat left waiting stalls the input only while the result register is still
// full and not being taken in the same cycle. Write the configuration
// registers only while no scan result is pending.
module wear_level_record_scanner
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,

    // Configuration write port
    input  wire logic                              write_enable,
    input  wire wlrs_pkg::reg_index_t              reg_index,
    input  wire logic [wlrs_pkg::REG_DATA_W-1:0]   write_data,

    // Slot beats
    input  wire logic                              slot_valid,
    output logic                                   slot_ready,
    input  wire logic [31:0]                       slot_first_word,
    input  wire logic [31:0]                       slot_last_word,
    input  wire logic                              final_slot,

    // Result beats
    output logic                                   result_valid,
    input  wire logic                              result_ready,
    output logic                                   record_found,
    output logic [wlrs_pkg::LEVEL_W-1:0]           newest_dc_level,
    output logic                                   newest_mode,
    output logic [wlrs_pkg::FIDX_W-1:0]            newest_file_index,
    output logic [wlrs_pkg::NEXT_SLOT_W-1:0]       next_slot,
    output logic [wlrs_pkg::SEQ_W-1:0]             next_sequence,
    output logic [31:0]                            new_record_first,
    output logic [31:0]                            new_record_last
);
    import wlrs_pkg::*;

    // Configuration registers
    logic [LEVEL_W-1:0] cfg_level_reg;
    logic               cfg_mode_reg;
    logic [FIDX_W-1:0]  cfg_fidx_reg;

    // Scan state
    slot_idx_t          slot_cnt_reg;
    logic               have_newest_reg;
    logic [SEQ_W-1:0]   newest_seq_reg;
    slot_idx_t          newest_slot_reg;
    rec_fields_t        newest_fields_reg;

    // Result register
    logic               result_valid_reg;
    logic               found_reg;
    rec_fields_t        out_fields_reg;
    logic [NEXT_SLOT_W-1:0] next_slot_reg;
    logic [SEQ_W-1:0]   next_seq_reg;
    logic [31:0]        rec_first_reg;
    logic [31:0]        rec_last_reg;

    logic               slot_accept;
    logic               rec_valid;
    logic [SEQ_W-1:0]   seq_in;
    logic [SEQ_W-1:0]   seq_diff;
    logic               take_new;

    slot_idx_t          slot_cnt_next;
    logic               have_newest_next;
    logic [SEQ_W-1:0]   newest_seq_next;
    slot_idx_t          newest_slot_next;
    rec_fields_t        newest_fields_next;

    logic [SLOT_W:0]    cnt_plus;
    logic [SLOT_W:0]    nslot_plus;
    slot_idx_t          nslot;
    logic [SLOT_W+NEXT_SLOT_W-1:0] nslot_ext;
    logic [SEQ_W-1:0]   nseq;
    rec_fields_t        fields_out;

    // Take a slot beat whenever the result register is free or draining
    assign slot_ready  = !result_valid_reg || result_ready;
    assign slot_accept = slot_valid && slot_ready;

    // ---------------------------------------------------------------
    // Compare and keep
    // ---------------------------------------------------------------
    assign rec_valid = (slot_first_word[15:0] == MAGIC_LOW)
                    && (slot_last_word[31:16] == MAGIC_HIGH);
    assign seq_in    = slot_first_word[23:16];
    assign seq_diff  = seq_in - newest_seq_reg;
    // Newer when the wrapped difference has its top bit set; ties keep the old one
    assign take_new  = rec_valid && (!have_newest_reg || seq_diff[SEQ_W-1]);

    always_comb
    begin
        have_newest_next   = have_newest_reg;
        newest_seq_next    = newest_seq_reg;
        newest_slot_next   = newest_slot_reg;
        newest_fields_next = newest_fields_reg;
        if (take_new)
        begin
            have_newest_next              = 1'b1;
            newest_seq_next               = seq_in;
            newest_slot_next              = slot_cnt_reg;
            newest_fields_next.dc_level   = slot_first_word[29:24];
            newest_fields_next.mode       = slot_first_word[30];
            newest_fields_next.file_index = slot_last_word[15:0];
        end
    end

    // Advance the slot counter, wrapping at the store size
    assign cnt_plus = {1'b0, slot_cnt_reg} + 1'b1;
    always_comb
    begin
        if (cnt_plus >= (SLOT_W+1)'(SLOT_COUNT))
            slot_cnt_next = '0;
        else
            slot_cnt_next = cnt_plus[SLOT_W-1:0];
    end

    // ---------------------------------------------------------------
    // Result of a final beat
    // ---------------------------------------------------------------
    assign nslot_plus = {1'b0, newest_slot_next} + 1'b1;
    always_comb
    begin
        nslot      = '0;
        nseq       = SEQ_NONE;
        fields_out = '0;
        if (have_newest_next)
        begin
            nseq       = newest_seq_next - 1'b1;
            fields_out = newest_fields_next;
            // The slot after the newest wraps to 0 past the scanned store
            if (newest_slot_next >= slot_cnt_reg
                || nslot_plus >= (SLOT_W+1)'(SLOT_COUNT))
                nslot = '0;
            else
                nslot = nslot_plus[SLOT_W-1:0];
        end
    end

    assign nslot_ext = {{NEXT_SLOT_W{1'b0}}, nslot};

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_level_reg <= 6'd4;
            cfg_mode_reg  <= 1'b1;
            cfg_fidx_reg  <= '0;
        end
        else if (write_enable)
        begin
            case (reg_index)
                REG_DC_LEVEL:   cfg_level_reg <= write_data[LEVEL_W-1:0];
                REG_MODE:       cfg_mode_reg  <= write_data[0];
                REG_FILE_INDEX: cfg_fidx_reg  <= write_data[FIDX_W-1:0];
                default:        ;   // drop writes to unknown indexes
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_cnt_reg      <= '0;
            have_newest_reg   <= 1'b0;
            newest_seq_reg    <= '0;
            newest_slot_reg   <= '0;
            newest_fields_reg <= '0;
        end
        else if (slot_accept)
        begin
            if (final_slot)
            begin
                // Clear the scan state for the next pass
                slot_cnt_reg      <= '0;
                have_newest_reg   <= 1'b0;
                newest_seq_reg    <= '0;
                newest_slot_reg   <= '0;
                newest_fields_reg <= '0;
            end
            else
            begin
                slot_cnt_reg      <= slot_cnt_next;
                have_newest_reg   <= have_newest_next;
                newest_seq_reg    <= newest_seq_next;
                newest_slot_reg   <= newest_slot_next;
                newest_fields_reg <= newest_fields_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (slot_accept)
            result_valid_reg <= final_slot;
        else if (result_ready)
            result_valid_reg <= 1'b0;
    end

    // Result payload: load on a final beat, hold otherwise
    always_ff @(posedge clk)
    begin
        if (slot_accept && final_slot)
        begin
            found_reg      <= have_newest_next;
            out_fields_reg <= fields_out;
            next_slot_reg  <= nslot_ext[NEXT_SLOT_W-1:0];
            next_seq_reg   <= nseq;
            rec_first_reg  <= {1'b1, cfg_mode_reg, cfg_level_reg, nseq, MAGIC_LOW};
            rec_last_reg   <= {MAGIC_HIGH, cfg_fidx_reg};
        end
    end

    assign result_valid      = result_valid_reg;
    assign record_found      = found_reg;
    assign newest_dc_level   = out_fields_reg.dc_level;
    assign newest_mode       = out_fields_reg.mode;
    assign newest_file_index = out_fields_reg.file_index;
    assign next_slot         = next_slot_reg;
    assign next_sequence     = next_seq_reg;
    assign new_record_first  = rec_first_reg;
    assign new_record_last   = rec_last_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_final_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        slot_accept && final_slot |=> result_valid)
        else $error("final slot beat did not produce a result beat");

    a_plain_slot_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        slot_accept && !final_slot |=> !result_valid)
        else $error("result beat appeared without a final slot");

    a_scan_clears: assert property (@(posedge clk) disable iff (!rst_n)
        slot_accept && final_slot |=> (slot_cnt_reg == '0) && !have_newest_reg)
        else $error("scan state not cleared after final slot");

    a_not_found_defaults: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !record_found |-> (next_sequence == SEQ_NONE)
                                         && (next_slot == '0))
        else $error("empty scan gave wrong next slot or sequence");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> slot_ready)
        else $error("slot beat stalled with empty result register");

endmodule

`default_nettype wire

### test/tb.sv
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wlrs_pkg::*;

    localparam int ITEM_TARGET  = 1000;
    localparam int IDLE_PERCENT = 29;
    localparam int MAX_REPORTED = 10;
    // Longest run of cycles with no beat on either channel before giving up
    localparam int STALL_LIMIT  = 2000;
    // Index past the last register; writes to it must change nothing
    localparam reg_index_t REG_UNUSED = 2'd3;

    // One result beat, fields in port order
    typedef struct packed {
        logic                   found;
        logic [LEVEL_W-1:0]     dc_level;
        logic                   mode;
        logic [FIDX_W-1:0]      file_index;
        logic [NEXT_SLOT_W-1:0] next_slot;
        logic [SEQ_W-1:0]       next_seq;
        logic [31:0]            first_word;
        logic [31:0]            last_word;
    } scan_report_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   write_enable;
    reg_index_t             reg_index;
    logic [REG_DATA_W-1:0]  write_data;
    logic                   slot_valid;
    logic                   slot_ready;
    logic [31:0]            slot_first_word;
    logic [31:0]            slot_last_word;
    logic                   final_slot;
    logic                   result_valid;
    logic                   result_ready = 1'b0;
    logic                   record_found;
    logic [LEVEL_W-1:0]     newest_dc_level;
    logic                   newest_mode;
    logic [FIDX_W-1:0]      newest_file_index;
    logic [NEXT_SLOT_W-1:0] next_slot;
    logic [SEQ_W-1:0]       next_sequence;
    logic [31:0]            new_record_first;
    logic [31:0]            new_record_last;

    // Shadow of the scanner: scan position, newest record kept, registers
    int                     scan_pos;
    logic                   kept_valid;
    logic [SEQ_W-1:0]       kept_seq;
    int                     kept_slot;
    rec_fields_t            kept_fields;
    logic [LEVEL_W-1:0]     cfg_level;
    logic                   cfg_mode;
    logic [FIDX_W-1:0]      cfg_file_index;

    scan_report_t           pending_reports[$];

    int                     slots_sent = 0;
    int                     error_count = 0;
    int                     quiet_cycles = 0;
    bit                     sender_steady = 1'b0;
    bit                     sink_steady = 1'b0;

    wear_level_record_scanner uut
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .write_enable      (write_enable),
        .reg_index         (reg_index),
        .write_data        (write_data),
        .slot_valid        (slot_valid),
        .slot_ready        (slot_ready),
        .slot_first_word   (slot_first_word),
        .slot_last_word    (slot_last_word),
        .final_slot        (final_slot),
        .result_valid      (result_valid),
        .result_ready      (result_ready),
        .record_found      (record_found),
        .newest_dc_level   (newest_dc_level),
        .newest_mode       (newest_mode),
        .newest_file_index (newest_file_index),
        .next_slot         (next_slot),
        .next_sequence     (next_sequence),
        .new_record_first  (new_record_first),
        .new_record_last   (new_record_last)
    );

    always #6 clk = ~clk;

    // Drop the scan state back to its cleared form, as the block does after
    // every final slot and at reset.
    task automatic clear_scan_shadow();
        scan_pos    = 0;
        kept_valid  = 1'b0;
        kept_seq    = '0;
        kept_slot   = 0;
        kept_fields = '0;
    endtask

    // Fold one accepted slot into the shadow state and, on the final slot,
    // queue the result beat the block owes us.
    task automatic track_newest_record(input logic [31:0] w0, input logic [31:0] w3,
                                       input logic last);
        logic [SEQ_W-1:0] seq;
        logic [SEQ_W-1:0] gap;
        scan_report_t     rep;
        int               after;
        seq = w0[23:16];
        gap = seq - kept_seq;
        // A record is newer when the wrapped distance from the kept sequence
        // is half the range or more; an equal sequence keeps the earlier slot.
        if (w0[15:0] == MAGIC_LOW && w3[31:16] == MAGIC_HIGH && (!kept_valid || gap[SEQ_W-1]))
        begin
            kept_valid             = 1'b1;
            kept_seq               = seq;
            kept_slot              = scan_pos;
            kept_fields.dc_level   = w0[29:24];
            kept_fields.mode       = w0[30];
            kept_fields.file_index = w3[15:0];
        end
        if (!last)
        begin
            scan_pos = (scan_pos + 1 >= SLOT_COUNT) ? 0 : scan_pos + 1;
        end
        else
        begin
            rep = '0;
            if (kept_valid)
            begin
                rep.found      = 1'b1;
                rep.dc_level   = kept_fields.dc_level;
                rep.mode       = kept_fields.mode;
                rep.file_index = kept_fields.file_index;
                rep.next_seq   = kept_seq - 1'b1;
                // The slot after the newest lies outside the scanned store when
                // the newest sits in the final slot, past a wrap, or at the top.
                after = kept_slot + 1;
                if (kept_slot >= scan_pos || after >= SLOT_COUNT)
                    after = 0;
                rep.next_slot  = after[NEXT_SLOT_W-1:0];
            end
            else
            begin
                rep.next_seq   = SEQ_NONE;
            end
            rep.first_word = {1'b1, cfg_mode, cfg_level, rep.next_seq, MAGIC_LOW};
            rep.last_word  = {MAGIC_HIGH, cfg_file_index};
            pending_reports.push_back(rep);
            clear_scan_shadow();
        end
    endtask

    // Send one slot beat. Enter and leave at a falling edge; valid stays high
    // on return so back-to-back beats need no extra assignment.
    task automatic send_slot(input logic [31:0] w0, input logic [31:0] w3, input logic last);
        if (!sender_steady)
        begin
            while ($urandom_range(0, 99) < IDLE_PERCENT)
            begin
                slot_valid <= 1'b0;
                @(negedge clk);
            end
        end
        slot_valid      <= 1'b1;
        slot_first_word <= w0;
        slot_last_word  <= w3;
        final_slot      <= last;
        @(posedge clk);
        while (!slot_ready)
            @(posedge clk);
        track_newest_record(w0, w3, last);
        slots_sent++;
        @(negedge clk);
    endtask

    // Hold off the sender until every queued result beat has arrived, then
    // let the result register settle.
    task automatic wait_for_reports();
        slot_valid <= 1'b0;
        @(negedge clk);
        while (pending_reports.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Write one register; the shadow keeps only the bits the register holds.
    task automatic write_register(input reg_index_t idx, input logic [REG_DATA_W-1:0] data);
        write_enable <= 1'b1;
        reg_index    <= idx;
        write_data   <= data;
        case (idx)
            REG_DC_LEVEL:   cfg_level      = data[LEVEL_W-1:0];
            REG_MODE:       cfg_mode       = data[0];
            REG_FILE_INDEX: cfg_file_index = data[FIDX_W-1:0];
            default:        ;
        endcase
        @(negedge clk);
        write_enable <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [31:0] record_first(input logic [SEQ_W-1:0] seq,
                                                 input logic [LEVEL_W-1:0] level,
                                                 input logic mode);
        return {1'b0, mode, level, seq, MAGIC_LOW};
    endfunction

    function automatic logic [31:0] record_last(input logic [FIDX_W-1:0] fidx);
        return {MAGIC_HIGH, fidx};
    endfunction

    // Build a random slot: mostly valid records, half of them with sequences
    // clustered near seq_base, the rest half-magic, near-miss magic or plain noise.
    task automatic make_random_slot(input logic [SEQ_W-1:0] seq_base,
                                    output logic [31:0] w0, output logic [31:0] w3);
        int pick;
        w0   = $urandom;
        w3   = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 65)
        begin
            w0[15:0]  = MAGIC_LOW;
            w3[31:16] = MAGIC_HIGH;
            if ($urandom_range(0, 1) == 1)
                w0[23:16] = seq_base + SEQ_W'($urandom_range(0, 6)) - 8'd3;
        end
        else if (pick < 75)
        begin
            w0[15:0] = MAGIC_LOW;
        end
        else if (pick < 85)
        begin
            w3[31:16] = MAGIC_HIGH;
        end
        else if (pick < 93)
        begin
            w0[15:0]  = MAGIC_LOW;
            w3[31:16] = MAGIC_HIGH;
            if ($urandom_range(0, 1) == 1)
                w0 = w0 ^ (32'd1 << $urandom_range(0, 15));
            else
                w3 = w3 ^ (32'd1 << $urandom_range(16, 31));
        end
    endtask

    task automatic run_random_scan(input int length);
        logic [SEQ_W-1:0] seq_base;
        logic [31:0]      w0;
        logic [31:0]      w3;
        seq_base = SEQ_W'($urandom);
        for (int i = 0; i < length; i++)
        begin
            make_random_slot(seq_base, w0, w3);
            send_slot(w0, w3, i == length - 1);
        end
    endtask

    // Scan of noise slots with a single valid record at position mark.
    task automatic run_marked_scan(input int length, input int mark, input logic [SEQ_W-1:0] seq);
        logic [31:0] w0;
        logic [31:0] w3;
        for (int i = 0; i < length; i++)
        begin
            w0 = $urandom;
            w3 = $urandom;
            if (i == mark)
            begin
                w0[15:0]  = MAGIC_LOW;
                w0[23:16] = seq;
                w3[31:16] = MAGIC_HIGH;
            end
            else
            begin
                w3[31:16] = ~MAGIC_HIGH;
            end
            send_slot(w0, w3, i == length - 1);
        end
    endtask

    // Field extremes, ties, wrapped sequence compares and empty scans, all
    // under the reset register values.
    task automatic test_directed_cases();
        // empty store: all-zero and all-ones slots carry no record
        send_slot(32'h0000_0000, 32'h0000_0000, 1'b1);
        send_slot(32'hffff_ffff, 32'hffff_ffff, 1'b1);
        // lone record in the final slot, every field at its top value
        send_slot(32'hffff_8fea, 32'hd591_ffff, 1'b1);
        // older record, broken low magic, then a tie: the first of the tie wins
        send_slot(record_first(8'h05, 6'd0, 1'b0), record_last(16'h0000), 1'b0);
        send_slot(record_first(8'h01, 6'd9, 1'b1) ^ 32'd1, record_last(16'h1111), 1'b0);
        send_slot(record_first(8'h03, 6'h15, 1'b0), record_last(16'h1234), 1'b0);
        send_slot(record_first(8'h03, 6'h2a, 1'b1), record_last(16'habcd), 1'b0);
        send_slot(record_first(8'h00, 6'h3f, 1'b1), 32'hd590_5555, 1'b1);
        // wraparound compare, including a distance of exactly half the range
        send_slot(record_first(8'h02, 6'd1, 1'b0), record_last(16'h0001), 1'b0);
        send_slot(record_first(8'hfe, 6'd2, 1'b1), record_last(16'h0002), 1'b0);
        send_slot(record_first(8'h7e, 6'd3, 1'b0), record_last(16'h0003), 1'b0);
        send_slot(record_first(8'h7f, 6'd4, 1'b1), record_last(16'h0004), 1'b1);
        // sequence zero: the next sequence wraps to the top
        send_slot(record_first(8'h00, 6'd0, 1'b0), record_last(16'h0000), 1'b0);
        send_slot(32'h1234_5678, 32'h9abc_def0, 1'b1);
    endtask

    // Walk the write registers through their extremes, including bits above
    // each register's width and the unused index, with short scans between.
    task automatic test_config_registers();
        wait_for_reports();
        write_register(REG_DC_LEVEL, 16'hffff);
        write_register(REG_MODE, 16'hfffe);
        write_register(REG_FILE_INDEX, 16'hffff);
        write_register(REG_UNUSED, 16'h0000);
        run_random_scan(3);
        send_slot(32'h0, 32'h0, 1'b1);
        wait_for_reports();
        write_register(REG_DC_LEVEL, 16'h0000);
        write_register(REG_MODE, 16'h0001);
        write_register(REG_FILE_INDEX, 16'h0000);
        write_register(REG_UNUSED, 16'hffff);
        run_random_scan(4);
        run_random_scan(1);
        wait_for_reports();
        write_register(REG_DC_LEVEL, 16'($urandom));
        write_register(REG_MODE, 16'($urandom));
        write_register(REG_FILE_INDEX, 16'($urandom));
        run_random_scan(5);
    endtask

    // Scans around and past the store size, so the slot counter and the next
    // slot both wrap.
    task automatic test_long_scans();
        run_marked_scan(SLOT_COUNT, SLOT_COUNT - 1, 8'h40);
        run_marked_scan(SLOT_COUNT, SLOT_COUNT - 2, 8'h80);
        run_marked_scan(SLOT_COUNT + 2, SLOT_COUNT - 1, 8'h01);
        run_marked_scan(SLOT_COUNT + 22, SLOT_COUNT + 12, 8'hc3);
        run_marked_scan(SLOT_COUNT + 22, 50, 8'h00);
    endtask

    // Mostly short scans, some medium, a few past the store size; registers
    // change now and then once the block has drained. Stop once the whole
    // run has sent its share of slot beats.
    task automatic test_random_scans();
        int scans;
        int pick;
        int length;
        scans = 0;
        while (slots_sent < ITEM_TARGET)
        begin
            // one long stretch with neither side idling
            if (scans == 3)
            begin
                sender_steady = 1'b1;
                sink_steady   = 1'b1;
            end
            if (scans == 13)
            begin
                sender_steady = 1'b0;
                sink_steady   = 1'b0;
            end
            if (scans % 9 == 8)
            begin
                wait_for_reports();
                write_register(reg_index_t'($urandom_range(0, 3)), 16'($urandom));
                write_register(reg_index_t'($urandom_range(0, 3)), 16'($urandom));
            end
            pick = $urandom_range(0, 99);
            if (pick < 84)
                length = $urandom_range(1, 10);
            else if (pick < 96)
                length = $urandom_range(11, 40);
            else
                length = $urandom_range(SLOT_COUNT + 1, SLOT_COUNT + 60);
            run_random_scan(length);
            scans++;
        end
    endtask

    // Result side: stall at random except during the steady stretch.
    always @(negedge clk)
    begin
        result_ready <= sink_steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got)
        begin
            if (error_count < MAX_REPORTED)
                $display("%0t: %s mismatch: expected %h, got %h", $realtime, name, want, got);
            error_count++;
        end
    endtask

    // Compare each accepted result beat against the oldest queued report.
    always @(posedge clk)
    begin
        scan_report_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_reports.size() == 0)
            begin
                if (error_count < MAX_REPORTED)
                    $display("%0t: result beat with no scan pending", $realtime);
                error_count++;
            end
            else
            begin
                want = pending_reports.pop_front();
                check_field("record_found", 32'(want.found), 32'(record_found));
                check_field("newest_dc_level", 32'(want.dc_level), 32'(newest_dc_level));
                check_field("newest_mode", 32'(want.mode), 32'(newest_mode));
                check_field("newest_file_index", 32'(want.file_index), 32'(newest_file_index));
                check_field("next_slot", 32'(want.next_slot), 32'(next_slot));
                check_field("next_sequence", 32'(want.next_seq), 32'(next_sequence));
                check_field("new_record_first", want.first_word, new_record_first);
                check_field("new_record_last", want.last_word, new_record_last);
            end
        end
    end

    // Watchdog: any beat or register write counts as progress.
    always @(posedge clk)
    begin
        if ((slot_valid && slot_ready) || (result_valid && result_ready) || write_enable)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no beat for %0d cycles", quiet_cycles);
            $display("CHECKS FAILED");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        write_enable    = 1'b0;
        reg_index       = REG_DC_LEVEL;
        write_data      = '0;
        slot_valid      = 1'b0;
        slot_first_word = '0;
        slot_last_word  = '0;
        final_slot      = 1'b0;
        cfg_level       = 6'd4;
        cfg_mode        = 1'b1;
        cfg_file_index  = '0;
        clear_scan_shadow();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_cases();
        test_config_registers();
        test_long_scans();
        test_random_scans();

        wait_for_reports();
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire

### wear_level_record_scanner.f
design/wlrs_pkg.sv
design/wear_level_record_scanner.sv
test/tb.sv
